/* hdl/mst_pkg.sv */
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types, codes and default sizes for the spanning tree engine.
// ----------------------------------------------------------------------------
package mst_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_EDGES_DEF    = 256;
	localparam int WEIGHT_BITS_DEF  = 16;

	localparam int FUNC_W   = 2;
	localparam int PORT_VW  = 6;
	localparam int PORT_WW  = 16;
	localparam int CFG_W    = 7;
	localparam int STATUS_W = 2;

	localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_RSVD  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_VTX = 2'd2;

	localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic [PORT_VW-1:0]        src;
		logic [PORT_VW-1:0]        dst;
		logic signed [PORT_WW-1:0] weight;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PORT_VW-1:0]  vertex;
		logic [PORT_VW-1:0]  parent;
		logic                has_parent;
		logic                last;
	} result_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ADD_RD,
		S_ADD_W1,
		S_ADD_W2,
		S_RESP,
		S_INIT,
		S_POP0,
		S_POP1,
		S_POP2,
		S_SD_L,
		S_SD_R,
		S_SD_C,
		S_ADJ_H,
		S_ADJ_H2,
		S_EDGE,
		S_EDGE_R,
		S_EDGE_C,
		S_UP_R,
		S_UP_C,
		S_UP_F,
		S_OUT_R,
		S_OUT_W
	} state_t;

endpackage

/* hdl/mst_ram.sv */
// ----------------------------------------------------------------------------
// mst_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module mst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/mst_core.sv */
// ----------------------------------------------------------------------------
// mst_core
// Edge store, indexed heap and the sequencer that runs Prim's algorithm.
// ----------------------------------------------------------------------------
module mst_core import mst_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = MAX_EDGES_DEF,
	parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF,
	localparam int HW = $clog2(MAX_VERTICES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  item_t         item,
	output logic          in_stall,
	input  logic [HW-1:0] n_act,
	output logic          res_valid,
	input  logic          res_ready,
	output result_t       res
);

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int ED  = 2 * MAX_EDGES;
	localparam int EW  = $clog2(ED);
	localparam int PW  = $clog2(ED + 1);
	localparam int WB  = WEIGHT_BITS;
	localparam int KW  = WEIGHT_BITS + 2;
	localparam int HPW = VW + KW;
	localparam int VIW = KW + VW + 1;
	localparam int ENW = VW + WB + PW;
	localparam logic [PW-1:0] NIL = PW'(ED);
	localparam logic [KW-1:0] INF = {2'b01, {WB{1'b0}}};

	state_t state_q, state_d;

	logic [PORT_VW-1:0]  s_q, s_d, d_q, d_d;
	logic [WB-1:0]       w_q, w_d;
	logic [STATUS_W-1:0] st_q, st_d;
	logic [PW-1:0]       cnt_q, cnt_d;
	logic [MAX_VERTICES-1:0] hv_q, hv_d;
	logic [HW-1:0]       hs_q, hs_d;
	logic [VW-1:0]       i_q, i_d;
	logic [VW-1:0]       u_q, u_d;
	logic [VW-1:0]       cv_q, cv_d;
	logic [KW-1:0]       ck_q, ck_d;
	logic [VW-1:0]       bi_q, bi_d, bv_q, bv_d;
	logic [KW-1:0]       bk_q, bk_d;
	logic                bself_q, bself_d;
	logic [PW-1:0]       e_q, e_d, nx_q, nx_d;
	logic [VW-1:0]       t_q, t_d;
	logic [KW-1:0]       ew_q, ew_d;

	// RAM ports
	logic heap_we, heap_re, vpos_we, vpos_re, vinf_we, vinf_re;
	logic head_we, head_re, ent_we, ent_re;
	logic [VW-1:0]  heap_wa, heap_ra, vpos_wa, vpos_ra, vinf_wa, vinf_ra;
	logic [VW-1:0]  head_wa, head_ra;
	logic [EW-1:0]  ent_wa, ent_ra;
	logic [HPW-1:0] heap_wd, heap_rd;
	logic [VW-1:0]  vpos_wd, vpos_rd;
	logic [VIW-1:0] vinf_wd, vinf_rd;
	logic [PW-1:0]  head_wd, head_rd;
	logic [ENW-1:0] ent_wd, ent_rd;

	// shared key comparator
	logic signed [KW-1:0] cmp_a, cmp_b;
	logic                 key_lt;
	assign key_lt = cmp_a < cmp_b;

	logic [VW-1:0]   rd_hv;
	logic [KW-1:0]   rd_hk;
	logic [VW+1:0]   l_idx, r_idx, hs_ext;
	logic            l_ok, r_ok;
	logic [VW-1:0]   par_idx;
	logic [HW-1:0]   n_last;
	logic signed [31:0] w32;

	assign rd_hv   = heap_rd[HPW-1:KW];
	assign rd_hk   = heap_rd[KW-1:0];
	assign l_idx   = {1'b0, i_q, 1'b1};
	assign r_idx   = l_idx + (VW+2)'(1);
	assign hs_ext  = (VW+2)'(hs_q);
	assign l_ok    = l_idx < hs_ext;
	assign r_ok    = r_idx < hs_ext;
	assign par_idx = (i_q - VW'(1)) >> 1;
	assign n_last  = n_act - HW'(1);
	assign w32     = 32'(item.weight);

	mst_ram #(.WIDTH(HPW), .DEPTH(MAX_VERTICES)) u_heap (
		.clk, .we(heap_we), .waddr(heap_wa), .wdata(heap_wd),
		.re(heap_re), .raddr(heap_ra), .rdata(heap_rd)
	);
	mst_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vpos (
		.clk, .we(vpos_we), .waddr(vpos_wa), .wdata(vpos_wd),
		.re(vpos_re), .raddr(vpos_ra), .rdata(vpos_rd)
	);
	mst_ram #(.WIDTH(VIW), .DEPTH(MAX_VERTICES)) u_vinf (
		.clk, .we(vinf_we), .waddr(vinf_wa), .wdata(vinf_wd),
		.re(vinf_re), .raddr(vinf_ra), .rdata(vinf_rd)
	);
	mst_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_head (
		.clk, .we(head_we), .waddr(head_wa), .wdata(head_wd),
		.re(head_re), .raddr(head_ra), .rdata(head_rd)
	);
	mst_ram #(.WIDTH(ENW), .DEPTH(ED)) u_ent (
		.clk, .we(ent_we), .waddr(ent_wa), .wdata(ent_wd),
		.re(ent_re), .raddr(ent_ra), .rdata(ent_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			hv_q    <= '0;
			hs_q    <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			hv_q    <= hv_d;
			hs_q    <= hs_d;
		end
	end

	always_ff @(posedge clk) begin
		s_q <= s_d; d_q <= d_d; w_q <= w_d; st_q <= st_d;
		i_q <= i_d; u_q <= u_d; cv_q <= cv_d; ck_q <= ck_d;
		bi_q <= bi_d; bv_q <= bv_d; bk_q <= bk_d; bself_q <= bself_d;
		e_q <= e_d; nx_q <= nx_d; t_q <= t_d; ew_q <= ew_d;
	end

	always_comb begin
		logic [PW-1:0] nlink;
		logic          take_r;
		state_d = state_q;
		s_d = s_q; d_d = d_q; w_d = w_q; st_d = st_q;
		cnt_d = cnt_q; hv_d = hv_q; hs_d = hs_q;
		i_d = i_q; u_d = u_q; cv_d = cv_q; ck_d = ck_q;
		bi_d = bi_q; bv_d = bv_q; bk_d = bk_q; bself_d = bself_q;
		e_d = e_q; nx_d = nx_q; t_d = t_q; ew_d = ew_q;
		nlink = NIL;
		take_r = 1'b0;

		heap_we = 1'b0; heap_wa = '0; heap_wd = '0; heap_re = 1'b0; heap_ra = '0;
		vpos_we = 1'b0; vpos_wa = '0; vpos_wd = '0; vpos_re = 1'b0; vpos_ra = '0;
		vinf_we = 1'b0; vinf_wa = '0; vinf_wd = '0; vinf_re = 1'b0; vinf_ra = '0;
		head_we = 1'b0; head_wa = '0; head_wd = '0; head_re = 1'b0; head_ra = '0;
		ent_we  = 1'b0; ent_wa  = '0; ent_wd  = '0; ent_re  = 1'b0; ent_ra  = '0;
		cmp_a = '0; cmp_b = '0;

		in_stall  = (state_q != S_IDLE);
		res_valid = 1'b0;
		res       = '0;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					s_d  = item.src;
					d_d  = item.dst;
					w_d  = w32[WB-1:0];
					st_d = ST_OK;
					unique case (item.func)
						FUNC_ADD: begin
							if (32'(item.src) >= 32'(n_act) || 32'(item.dst) >= 32'(n_act)) begin
								st_d    = ST_BAD_VTX;
								state_d = S_RESP;
							end else if (32'(cnt_q) + 32'd2 > 32'(ED)) begin
								st_d    = ST_FULL;
								state_d = S_RESP;
							end else begin
								state_d = S_ADD_RD;
							end
						end
						FUNC_RUN: begin
							i_d     = '0;
							state_d = S_INIT;
						end
						FUNC_CLEAR: begin
							hv_d    = '0;
							cnt_d   = '0;
							state_d = S_RESP;
						end
						default: state_d = S_RESP;
					endcase
				end
			end
			S_ADD_RD: begin
				head_re = 1'b1;
				head_ra = VW'(s_q);
				state_d = S_ADD_W1;
			end
			S_ADD_W1: begin
				nlink   = hv_q[VW'(s_q)] ? head_rd : NIL;
				ent_we  = 1'b1;
				ent_wa  = EW'(cnt_q);
				ent_wd  = {VW'(d_q), w_q, nlink};
				head_we = 1'b1;
				head_wa = VW'(s_q);
				head_wd = cnt_q;
				hv_d[VW'(s_q)] = 1'b1;
				head_re = 1'b1;
				head_ra = VW'(d_q);
				state_d = S_ADD_W2;
			end
			S_ADD_W2: begin
				// self loop: second entry links to the first one just written
				if (d_q == s_q) begin
					nlink = cnt_q;
				end else begin
					nlink = hv_q[VW'(d_q)] ? head_rd : NIL;
				end
				ent_we  = 1'b1;
				ent_wa  = EW'(cnt_q + PW'(1));
				ent_wd  = {VW'(s_q), w_q, nlink};
				head_we = 1'b1;
				head_wa = VW'(d_q);
				head_wd = cnt_q + PW'(1);
				hv_d[VW'(d_q)] = 1'b1;
				cnt_d   = cnt_q + PW'(2);
				state_d = S_RESP;
			end
			S_RESP: begin
				res_valid  = 1'b1;
				res.status = st_q;
				res.last   = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			S_INIT: begin
				heap_we = 1'b1;
				heap_wa = i_q;
				heap_wd = {i_q, (i_q == '0) ? KW'(0) : INF};
				vpos_we = 1'b1;
				vpos_wa = i_q;
				vpos_wd = i_q;
				vinf_we = 1'b1;
				vinf_wa = i_q;
				vinf_wd = {(i_q == '0) ? KW'(0) : INF, VW'(0), 1'b0};
				if (HW'(i_q) == n_last) begin
					hs_d    = n_act;
					state_d = S_POP0;
				end else begin
					i_d = i_q + VW'(1);
				end
			end
			S_POP0: begin
				heap_re = 1'b1;
				heap_ra = '0;
				state_d = S_POP1;
			end
			S_POP1: begin
				u_d     = rd_hv;
				heap_re = 1'b1;
				heap_ra = VW'(hs_q - HW'(1));
				state_d = S_POP2;
			end
			S_POP2: begin
				cv_d    = rd_hv;
				ck_d    = rd_hk;
				vpos_we = 1'b1;
				vpos_wa = u_q;
				vpos_wd = VW'(hs_q - HW'(1));
				hs_d    = hs_q - HW'(1);
				i_d     = '0;
				state_d = S_SD_L;
			end
			S_SD_L: begin
				heap_re = 1'b1;
				heap_ra = l_idx[VW-1:0];
				state_d = S_SD_R;
			end
			S_SD_R: begin
				cmp_a = $signed(rd_hk);
				cmp_b = $signed(ck_q);
				if (l_ok && key_lt) begin
					bi_d = l_idx[VW-1:0]; bv_d = rd_hv; bk_d = rd_hk; bself_d = 1'b0;
				end else begin
					bi_d = i_q; bv_d = cv_q; bk_d = ck_q; bself_d = 1'b1;
				end
				heap_re = 1'b1;
				heap_ra = r_idx[VW-1:0];
				state_d = S_SD_C;
			end
			S_SD_C: begin
				cmp_a  = $signed(rd_hk);
				cmp_b  = $signed(bk_q);
				take_r = r_ok && key_lt;
				heap_we = 1'b1;
				heap_wa = i_q;
				vpos_we = 1'b1;
				vpos_wa = take_r ? rd_hv : bv_q;
				vpos_wd = i_q;
				if (bself_q && !take_r) begin
					heap_wd = {cv_q, ck_q};
					state_d = S_ADJ_H;
				end else begin
					heap_wd = take_r ? heap_rd : {bv_q, bk_q};
					i_d     = take_r ? r_idx[VW-1:0] : bi_q;
					state_d = S_SD_L;
				end
			end
			S_ADJ_H: begin
				head_re = 1'b1;
				head_ra = u_q;
				state_d = S_ADJ_H2;
			end
			S_ADJ_H2: begin
				e_d     = hv_q[u_q] ? head_rd : NIL;
				state_d = S_EDGE;
			end
			S_EDGE: begin
				if (e_q < cnt_q) begin
					ent_re  = 1'b1;
					ent_ra  = EW'(e_q);
					state_d = S_EDGE_R;
				end else if (hs_q == '0) begin
					i_d     = VW'(1);
					state_d = S_OUT_R;
				end else begin
					state_d = S_POP0;
				end
			end
			S_EDGE_R: begin
				t_d     = ent_rd[ENW-1:WB+PW];
				ew_d    = KW'($signed(ent_rd[WB+PW-1:PW]));
				nx_d    = ent_rd[PW-1:0];
				vpos_re = 1'b1;
				vpos_ra = ent_rd[ENW-1:WB+PW];
				vinf_re = 1'b1;
				vinf_ra = ent_rd[ENW-1:WB+PW];
				state_d = S_EDGE_C;
			end
			S_EDGE_C: begin
				cmp_a = $signed(ew_q);
				cmp_b = $signed(vinf_rd[VIW-1:VW+1]);
				if (HW'(t_q) < n_act && HW'(vpos_rd) < hs_q && key_lt) begin
					vinf_we = 1'b1;
					vinf_wa = t_q;
					vinf_wd = {ew_q, u_q, 1'b1};
					i_d     = vpos_rd;
					cv_d    = t_q;
					ck_d    = ew_q;
					state_d = S_UP_R;
				end else begin
					e_d     = nx_q;
					state_d = S_EDGE;
				end
			end
			S_UP_R: begin
				if (i_q == '0) begin
					state_d = S_UP_F;
				end else begin
					heap_re = 1'b1;
					heap_ra = par_idx;
					state_d = S_UP_C;
				end
			end
			S_UP_C: begin
				cmp_a = $signed(ck_q);
				cmp_b = $signed(rd_hk);
				if (key_lt) begin
					heap_we = 1'b1;
					heap_wa = i_q;
					heap_wd = heap_rd;
					vpos_we = 1'b1;
					vpos_wa = rd_hv;
					vpos_wd = i_q;
					i_d     = par_idx;
					state_d = S_UP_R;
				end else begin
					state_d = S_UP_F;
				end
			end
			S_UP_F: begin
				heap_we = 1'b1;
				heap_wa = i_q;
				heap_wd = {cv_q, ck_q};
				vpos_we = 1'b1;
				vpos_wa = cv_q;
				vpos_wd = i_q;
				e_d     = nx_q;
				state_d = S_EDGE;
			end
			S_OUT_R: begin
				vinf_re = 1'b1;
				vinf_ra = i_q;
				state_d = S_OUT_W;
			end
			S_OUT_W: begin
				res_valid      = 1'b1;
				res.status     = ST_OK;
				res.vertex     = PORT_VW'(i_q);
				res.has_parent = vinf_rd[0];
				res.parent     = vinf_rd[0] ? PORT_VW'(vinf_rd[VW:1]) : '0;
				res.last       = (HW'(i_q) == n_last);
				if (res_ready) begin
					if (HW'(i_q) == n_last) begin
						state_d = S_IDLE;
					end else begin
						i_d     = i_q + VW'(1);
						state_d = S_OUT_R;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* hdl/prim_minimum_spanning_tree_top.sv */
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree_top
// Prim spanning tree engine: edge loading, tree run, per-vertex parent report.
// ----------------------------------------------------------------------------
// Add edge: two head reads and two entry writes before the result.
// Clear / unknown: straight to the result. Run: init of every vertex, then per
//   vertex a heap pop, sift-down level by level and a head read; per edge entry
//   a read and check, per lowered key a sift-up; then each non-root vertex is reported.
// One item at a time; input stalls until its last result enters the output reg.
// Reset clears head valid bits, edge count and heap size at once; no sweep.
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree_top import mst_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = MAX_EDGES_DEF,
	parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// item in
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [FUNC_W-1:0]         func,
	input  logic [PORT_VW-1:0]        src_vertex,
	input  logic [PORT_VW-1:0]        dst_vertex,
	input  logic signed [PORT_WW-1:0] edge_weight,
	// result out
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [STATUS_W-1:0]       status,
	output logic [PORT_VW-1:0]        vertex,
	output logic [PORT_VW-1:0]        parent_vertex,
	output logic                      has_parent,
	output logic                      last,
	// vertex_count register write
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_W-1:0]          cfg_data
);

	localparam int HW = $clog2(MAX_VERTICES + 1);

	logic [CFG_W-1:0] vcount_q;
	logic [HW-1:0]    n_act;
	item_t            item;
	result_t          res, out_q;
	logic             res_valid, res_ready, out_valid_q;

	// config register; always writable; write it only while idle, the block does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RESET;
		end else if (cfg_valid) begin
			vcount_q <= cfg_data;
		end
	end

	// effective vertex count, clamped to [2, MAX_VERTICES]
	always_comb begin
		if (vcount_q < CFG_W'(2)) begin
			n_act = HW'(2);
		end else if (32'(vcount_q) > 32'(MAX_VERTICES)) begin
			n_act = HW'(MAX_VERTICES);
		end else begin
			n_act = HW'(vcount_q);
		end
	end

	assign item.func   = func;
	assign item.src    = src_vertex;
	assign item.dst    = dst_vertex;
	assign item.weight = edge_weight;

	mst_core #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES   (MAX_EDGES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_core (
		.clk,
		.arst_n,
		.in_valid,
		.item,
		.in_stall,
		.n_act,
		.res_valid,
		.res_ready,
		.res
	);

	// output register: frees the core while empty or as soon as the held item is taken
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign vertex        = out_q.vertex;
	assign parent_vertex = out_q.parent;
	assign has_parent    = out_q.has_parent;
	assign last          = out_q.last;

endmodule
